// ===== src/bdc_pkg.sv =====
// Shared types and constants for the button debounce, click and long-press block
package bdc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;
    localparam int MS_CFG_W    = 16;

    localparam logic [MS_CFG_W-1:0] FILTER_RESET = 16'd50;
    localparam logic [MS_CFG_W-1:0] LONG_RESET   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_TIME   = 3'd0,
        CFG_LONG_TIME     = 3'd1,
        CFG_SIMPLE_ENABLE = 3'd2,
        CFG_LONG_ENABLE   = 3'd3,
        CFG_SWAP_UP_DOWN  = 3'd4,
        CFG_SLEEP_MODE    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [MS_CFG_W-1:0]    filter_time;
        logic [MS_CFG_W-1:0]    long_time;
        logic [NUM_BUTTONS-1:0] simple_enable;
        logic [NUM_BUTTONS-1:0] long_enable;
        logic                   swap_up_down;
        logic                   sleep_mode;
    } t_cfg;

    typedef struct packed {
        logic                   tick;
        logic [NUM_BUTTONS-1:0] act;
        logic [NUM_BUTTONS-1:0] pushed;
        logic [TIME_W-1:0]      now;
    } t_entry;

endpackage

// ===== src/bdc_front.sv =====
// Front end: accept input items and classify which buttons each one qualifies
module bdc_front (
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [1:0]                      i_button_index,
    input  logic [bdc_pkg::TIME_W-1:0]      i_now_ms,
    input  logic [bdc_pkg::NUM_BUTTONS-1:0] i_raw_pressed,
    input  bdc_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output bdc_pkg::t_entry                 o_q_data
);
    import bdc_pkg::*;

    function automatic int pin_of(input int b, input logic swap);
        int p;
        p = b;
        if (swap && NUM_BUTTONS > 1) begin
            if (b == 0) begin
                p = NUM_BUTTONS - 1;
            end else if (b == NUM_BUTTONS - 1) begin
                p = 0;
            end
        end
        return p;
    endfunction

    logic edge_ok;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign edge_ok    = !i_cfg.sleep_mode && (int'(i_button_index) < NUM_BUTTONS);

    always_comb begin
        o_q_data.tick = !i_req_type;
        o_q_data.now  = i_now_ms;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (i_cfg.swap_up_down && NUM_BUTTONS > 1 && b == 0) begin
                o_q_data.pushed[b] = i_raw_pressed[NUM_BUTTONS-1];
            end else if (i_cfg.swap_up_down && NUM_BUTTONS > 1 && b == NUM_BUTTONS - 1) begin
                o_q_data.pushed[b] = i_raw_pressed[0];
            end else begin
                o_q_data.pushed[b] = i_raw_pressed[b];
            end
            if (!i_req_type) begin
                o_q_data.act[b] = 1'b1;
            end else begin
                o_q_data.act[b] = edge_ok &&
                    (int'(i_button_index) == pin_of(b, i_cfg.swap_up_down));
            end
        end
    end

endmodule

// ===== src/bdc_fifo.sv =====
// Short register queue between the classifying front end and the qualifier
module bdc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bdc_pkg::t_entry i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output bdc_pkg::t_entry o_data
);
    import bdc_pkg::*;

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wr;
    logic [QPTR_W-1:0]  n_rd;
    logic [QCNT_W-1:0]  n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/bdc_back.sv =====
// Back end: per-button debounce, click and long-press qualifiers with result register
module bdc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdc_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_valid,
    input  bdc_pkg::t_entry                 i_q_data,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bdc_pkg::NUM_BUTTONS-1:0] o_click_events,
    output logic [bdc_pkg::NUM_BUTTONS-1:0] o_long_events,
    output logic [bdc_pkg::TIME_W-1:0]      o_idle_ticks
);
    import bdc_pkg::*;

    logic [NUM_BUTTONS-1:0] r_ll;
    logic [NUM_BUTTONS-1:0] r_pv;
    logic [NUM_BUTTONS-1:0] r_ed;
    logic [TIME_W-1:0]      r_ct [NUM_BUTTONS];
    logic [TIME_W-1:0]      r_pt [NUM_BUTTONS];
    logic [TIME_W-1:0]      r_idle;
    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_click;
    logic [NUM_BUTTONS-1:0] r_long;

    logic [NUM_BUTTONS-1:0] n_ll;
    logic [NUM_BUTTONS-1:0] n_pv;
    logic [NUM_BUTTONS-1:0] n_ed;
    logic [TIME_W-1:0]      n_ct [NUM_BUTTONS];
    logic [TIME_W-1:0]      n_pt [NUM_BUTTONS];
    logic [TIME_W-1:0]      n_idle;
    logic [NUM_BUTTONS-1:0] n_click;
    logic [NUM_BUTTONS-1:0] n_long;

    logic [TIME_W-1:0]      d_chg [NUM_BUTTONS];
    logic [TIME_W-1:0]      d_press [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] filtered;
    logic [NUM_BUTTONS-1:0] pt_new;
    logic                   chg_any;
    logic                   pop;

    assign pop            = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop        = pop;
    assign o_out_valid    = r_out_valid;
    assign o_click_events = r_click;
    assign o_long_events  = r_long;
    assign o_idle_ticks   = r_idle;

    always_comb begin
        n_ll    = r_ll;
        n_pv    = r_pv;
        n_ed    = r_ed;
        n_click = '0;
        n_long  = '0;
        chg_any = 1'b0;
        pt_new  = '0;
        n_idle  = r_idle;
        if (pop && i_q_data.tick && (r_idle != '1)) begin
            n_idle = r_idle + 1'b1;
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_ct[b]     = r_ct[b];
            n_pt[b]     = r_pt[b];
            d_chg[b]    = i_q_data.now - r_ct[b];
            d_press[b]  = i_q_data.now - r_pt[b];
            filtered[b] = d_chg[b] > TIME_W'(i_cfg.filter_time);
            if (pop && i_q_data.act[b]) begin
                if (i_q_data.pushed[b] != r_ll[b]) begin
                    chg_any = 1'b1;
                    if (i_q_data.pushed[b] && filtered[b]) begin
                        n_pt[b]   = i_q_data.now;
                        pt_new[b] = 1'b1;
                        n_pv[b]   = 1'b1;
                        if (!r_ed[b] && i_cfg.simple_enable[b] && !i_cfg.long_enable[b]) begin
                            n_click[b] = 1'b1;
                            n_ed[b]    = 1'b1;
                        end
                    end
                    n_ct[b] = i_q_data.now;
                    n_ll[b] = i_q_data.pushed[b];
                end else if (!i_q_data.pushed[b] && r_pv[b] && filtered[b]) begin
                    if (!r_ed[b] && i_cfg.simple_enable[b] && i_cfg.long_enable[b]) begin
                        n_click[b] = 1'b1;
                    end
                    n_pv[b] = 1'b0;
                    n_ed[b] = 1'b0;
                end
                if (!n_ed[b] && i_cfg.long_enable[b] && i_q_data.pushed[b] && n_pv[b] &&
                    !pt_new[b] && (d_press[b] > TIME_W'(i_cfg.long_time))) begin
                    n_long[b] = 1'b1;
                    n_ed[b]   = 1'b1;
                end
            end
        end
        if (chg_any) begin
            n_idle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll        <= '0;
            r_pv        <= '0;
            r_ed        <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ct[b] <= '0;
                r_pt[b] <= '0;
            end
        end else begin
            r_ll   <= n_ll;
            r_pv   <= n_pv;
            r_ed   <= n_ed;
            r_idle <= n_idle;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ct[b] <= n_ct[b];
                r_pt[b] <= n_pt[b];
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_click <= n_click;
            r_long  <= n_long;
        end
    end

endmodule

// ===== src/button_debounce_click_long_press.sv =====
// Top level: three-button debounce with short click and long-press detection
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | req_type, button_index, now_ms, raw_pressed
//  out     | output    | o_out_valid / i_out_ready  | click_events, long_events, idle_ticks
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while the output is ready; an accepted item is written
// into the queue, then qualified by the back end into the result register. All
// buttons of an item are qualified in parallel by the back end. A two-entry queue
// decouples input acceptance from output stalls. Reset is synchronous.
module button_debounce_click_long_press (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [1:0]                       i_button_index,
    input  logic [bdc_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [bdc_pkg::NUM_BUTTONS-1:0]  i_raw_pressed,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bdc_pkg::NUM_BUTTONS-1:0]  o_click_events,
    output logic [bdc_pkg::NUM_BUTTONS-1:0]  o_long_events,
    output logic [bdc_pkg::TIME_W-1:0]       o_idle_ticks,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bdc_pkg::*;

    t_cfg   r_cfg;
    t_entry q_in;
    t_entry q_out;
    logic   q_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_time   <= FILTER_RESET;
            r_cfg.long_time     <= LONG_RESET;
            r_cfg.simple_enable <= '0;
            r_cfg.long_enable   <= '0;
            r_cfg.swap_up_down  <= 1'b0;
            r_cfg.sleep_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILTER_TIME:   r_cfg.filter_time   <= i_cfg_data;
                CFG_LONG_TIME:     r_cfg.long_time     <= i_cfg_data;
                CFG_SIMPLE_ENABLE: r_cfg.simple_enable <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_LONG_ENABLE:   r_cfg.long_enable   <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_SWAP_UP_DOWN:  r_cfg.swap_up_down  <= i_cfg_data[0];
                CFG_SLEEP_MODE:    r_cfg.sleep_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bdc_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_button_index (i_button_index),
        .i_now_ms       (i_now_ms),
        .i_raw_pressed  (i_raw_pressed),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    bdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    bdc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_click_events (o_click_events),
        .o_long_events  (o_long_events),
        .o_idle_ticks   (o_idle_ticks)
    );

endmodule

// ===== src/bdc_checker.sv =====
// Port-level checker for the button debounce block, bound to the top level
module bdc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [bdc_pkg::NUM_BUTTONS-1:0]  o_click_events,
    input  logic [bdc_pkg::NUM_BUTTONS-1:0]  o_long_events,
    input  logic [bdc_pkg::TIME_W-1:0]       o_idle_ticks
);
    import bdc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_click_events) &&
        $stable(o_long_events) && $stable(o_idle_ticks))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    a_click_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_click_events & o_long_events) == '0)
        else $error("click and long press on the same button in one item");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_idle_ticks) |-> o_out_valid &&
        ((o_idle_ticks == '0) || (o_idle_ticks == $past(o_idle_ticks) + 1'b1)))
        else $error("idle count moved other than by one tick or a clear");

endmodule

bind button_debounce_click_long_press bdc_checker u_bdc_checker (.*);

// ===== tb/tb_button_debounce_click_long_press.sv =====
// Testbench for the button debounce block: directed table, then random streams vs a predictor
`timescale 1ns / 1ps

module tb_button_debounce_click_long_press;
    import bdc_pkg::*;

    localparam logic       REQ_TICK    = 1'b0;
    localparam logic       REQ_EDGE    = 1'b1;
    localparam logic [1:0] PIN_UP      = 2'd0;
    localparam logic [1:0] PIN_SELECT  = 2'd1;
    localparam logic [1:0] PIN_DOWN    = 2'd2;
    localparam logic [1:0] PIN_NONE    = 2'd3;
    localparam int         HOLD_CYCLES = 200;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] clicks;
        logic [NUM_BUTTONS-1:0] longs;
        logic [TIME_W-1:0]      idle;
    } t_button_result;

    typedef struct packed {
        logic                   is_reg;
        t_cfg_idx               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   req;
        logic [1:0]             pin;
        logic [TIME_W-1:0]      stamp;
        logic [NUM_BUTTONS-1:0] raw;
        logic                   fixed;
        t_button_result         want;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_req_type = REQ_TICK;
    logic [1:0]             i_button_index = PIN_UP;
    logic [TIME_W-1:0]      i_now_ms = '0;
    logic [NUM_BUTTONS-1:0] i_raw_pressed = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [NUM_BUTTONS-1:0] o_click_events;
    logic [NUM_BUTTONS-1:0] o_long_events;
    logic [TIME_W-1:0]      o_idle_ticks;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_FILTER_TIME;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // expectation typed into the table, riding along with the item on the wire
    logic           want_fixed = 1'b0;
    t_button_result want_value = '0;

    int unsigned tx_idle_pct = 19;
    int unsigned rx_idle_pct = 75;
    logic        hold_req = 1'b0;
    logic        hold_served = 1'b0;

    // predictor copy of the configuration and per-button state
    logic [MS_CFG_W-1:0]    cf_filter = FILTER_RESET;
    logic [MS_CFG_W-1:0]    cf_long = LONG_RESET;
    logic [NUM_BUTTONS-1:0] cf_simple = '0;
    logic [NUM_BUTTONS-1:0] cf_long_en = '0;
    logic                   cf_swap = 1'b0;
    logic                   cf_sleep = 1'b0;
    logic [NUM_BUTTONS-1:0] level_now = '0;
    logic [NUM_BUTTONS-1:0] press_live = '0;
    logic [NUM_BUTTONS-1:0] fired = '0;
    logic [TIME_W-1:0]      changed_at [NUM_BUTTONS];
    logic [TIME_W-1:0]      pressed_at [NUM_BUTTONS];
    logic [TIME_W-1:0]      idle_run = '0;

    t_button_result pending_results [$];
    t_script_row    script [$];

    logic [TIME_W-1:0]      stamp_ms = '0;
    logic [NUM_BUTTONS-1:0] held_pins = '0;

    int unsigned mismatches = 0;
    int unsigned ticks_seen = 0;
    int unsigned edges_seen = 0;
    int unsigned results_seen = 0;
    int unsigned click_results = 0;
    int unsigned long_results = 0;
    int unsigned reg_writes = 0;

    button_debounce_click_long_press dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_button_index (i_button_index),
        .i_now_ms       (i_now_ms),
        .i_raw_pressed  (i_raw_pressed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_click_events (o_click_events),
        .o_long_events  (o_long_events),
        .o_idle_ticks   (o_idle_ticks),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            changed_at[b] = '0;
            pressed_at[b] = '0;
        end
    end

    function automatic int unsigned pin_for(int unsigned b);
        if (cf_swap && NUM_BUTTONS > 1) begin
            if (b == 0) return NUM_BUTTONS - 1;
            if (b == NUM_BUTTONS - 1) return 0;
        end
        return b;
    endfunction

    // returns {click, long press} for one button
    function automatic logic [1:0] qualify_button(int unsigned b, logic [TIME_W-1:0] stamp,
                                                  logic [NUM_BUTTONS-1:0] raw);
        logic              pushed;
        logic              filtered;
        logic              click_ev;
        logic              long_ev;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] held_for;
        pushed       = raw[pin_for(b)];
        since_change = stamp - changed_at[b];
        filtered     = since_change > {16'd0, cf_filter};
        click_ev     = 1'b0;
        long_ev      = 1'b0;
        if (pushed != level_now[b]) begin
            idle_run = '0;
            if (pushed && filtered) begin
                pressed_at[b] = stamp;
                press_live[b] = 1'b1;
                if (!fired[b] && cf_simple[b] && !cf_long_en[b]) begin
                    click_ev = 1'b1;
                    fired[b] = 1'b1;
                end
            end
            changed_at[b] = stamp;
            level_now[b]  = pushed;
        end else if (!pushed && press_live[b] && filtered) begin
            if (!fired[b] && cf_simple[b] && cf_long_en[b]) click_ev = 1'b1;
            press_live[b] = 1'b0;
            fired[b]      = 1'b0;
        end
        held_for = stamp - pressed_at[b];
        if (!fired[b] && cf_long_en[b] && pushed && press_live[b] &&
            held_for > {16'd0, cf_long}) begin
            long_ev  = 1'b1;
            fired[b] = 1'b1;
        end
        return {click_ev, long_ev};
    endfunction

    function automatic t_button_result predict_buttons(logic req, logic [1:0] pin,
                                                       logic [TIME_W-1:0] stamp,
                                                       logic [NUM_BUTTONS-1:0] raw);
        t_button_result r;
        logic [1:0]     ev;
        int unsigned    b;
        r = '0;
        if (req == REQ_TICK) begin
            if (idle_run != '1) idle_run = idle_run + 1'b1;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                ev = qualify_button(i, stamp, raw);
                r.clicks[i] = ev[1];
                r.longs[i]  = ev[0];
            end
        end else if (!cf_sleep && pin < NUM_BUTTONS) begin
            b  = pin_for(pin);
            ev = qualify_button(b, stamp, raw);
            r.clicks[b] = ev[1];
            r.longs[b]  = ev[0];
        end
        r.idle = idle_run;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_button_result got;
        t_button_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                got = predict_buttons(i_req_type, i_button_index, i_now_ms, i_raw_pressed);
                pending_results.push_back(want_fixed ? want_value : got);
                if (i_req_type == REQ_TICK) ticks_seen++;
                else edges_seen++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_click_events != '0) click_results++;
                if (o_long_events != '0) long_results++;
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: clicks %0h long %0h idle %0d",
                           o_click_events, o_long_events, o_idle_ticks);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_click_events !== want.clicks) begin
                        $error("click_events: expected %0h, actual %0h",
                               want.clicks, o_click_events);
                        mismatches++;
                    end
                    if (o_long_events !== want.longs) begin
                        $error("long_events: expected %0h, actual %0h",
                               want.longs, o_long_events);
                        mismatches++;
                    end
                    if (o_idle_ticks !== want.idle) begin
                        $error("idle_ticks: expected %0d, actual %0d", want.idle, o_idle_ticks);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic req, input logic [1:0] pin,
                             input logic [TIME_W-1:0] stamp,
                             input logic [NUM_BUTTONS-1:0] raw,
                             input logic fixed, input t_button_result want);
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_button_index <= pin;
        i_now_ms       <= stamp;
        i_raw_pressed  <= raw;
        want_fixed     <= fixed;
        want_value     <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FILTER_TIME:   cf_filter  = val[MS_CFG_W-1:0];
            CFG_LONG_TIME:     cf_long    = val[MS_CFG_W-1:0];
            CFG_SIMPLE_ENABLE: cf_simple  = val[NUM_BUTTONS-1:0];
            CFG_LONG_ENABLE:   cf_long_en = val[NUM_BUTTONS-1:0];
            CFG_SWAP_UP_DOWN:  cf_swap    = val[0];
            CFG_SLEEP_MODE:    cf_sleep   = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_time_ms(int unsigned top);
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return CFG_DATA_W'($urandom_range(top));
    endfunction

    task automatic configure_random();
        cfg_write(CFG_FILTER_TIME, pick_time_ms(40));
        cfg_write(CFG_LONG_TIME, pick_time_ms(300));
        cfg_write(CFG_SIMPLE_ENABLE, CFG_DATA_W'($urandom_range(7)));
        cfg_write(CFG_LONG_ENABLE, CFG_DATA_W'($urandom_range(7)));
        cfg_write(CFG_SWAP_UP_DOWN, CFG_DATA_W'($urandom_range(1)));
        cfg_write(CFG_SLEEP_MODE, CFG_DATA_W'($urandom_range(4) == 0));
    endtask

    // press and release buttons on a running timeline, steps sized around the filter and hold
    task automatic run_chunk(input int unsigned count);
        logic [TIME_W-1:0]      step;
        logic [NUM_BUTTONS-1:0] raw;
        logic [1:0]             pin;
        int unsigned            kind;
        for (int unsigned n = 0; n < count; n++) begin
            kind = $urandom_range(19);
            if (kind < 8) step = $urandom_range(cf_filter);
            else if (kind < 13) step = cf_filter + $urandom_range(3, 1);
            else if (kind < 17) step = cf_long + $urandom_range(3);
            else step = $urandom();
            stamp_ms = stamp_ms + step;
            pin = 2'($urandom_range(NUM_BUTTONS - 1));
            if ($urandom_range(3) == 0) held_pins[pin] = ~held_pins[pin];
            raw = ($urandom_range(19) == 0) ? NUM_BUTTONS'($urandom_range(7)) : held_pins;
            if ($urandom_range(12) == 0) pin = PIN_NONE;
            send_item(($urandom_range(9) < 7) ? REQ_TICK : REQ_EDGE, pin, stamp_ms, raw,
                      1'b0, '0);
        end
    endtask

    function automatic void row_item(logic req, logic [1:0] pin, logic [TIME_W-1:0] stamp,
                                     logic [NUM_BUTTONS-1:0] raw);
        t_script_row r;
        r       = '0;
        r.req   = req;
        r.pin   = pin;
        r.stamp = stamp;
        r.raw   = raw;
        script.push_back(r);
    endfunction

    function automatic void row_known(logic req, logic [1:0] pin, logic [TIME_W-1:0] stamp,
                                      logic [NUM_BUTTONS-1:0] raw,
                                      logic [NUM_BUTTONS-1:0] clicks,
                                      logic [NUM_BUTTONS-1:0] longs,
                                      logic [TIME_W-1:0] idle);
        t_script_row r;
        r             = '0;
        r.req         = req;
        r.pin         = pin;
        r.stamp       = stamp;
        r.raw         = raw;
        r.fixed       = 1'b1;
        r.want.clicks = clicks;
        r.want.longs  = longs;
        r.want.idle   = idle;
        script.push_back(r);
    endfunction

    function automatic void row_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        t_script_row r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        script.push_back(r);
    endfunction

    initial begin
        t_script_row row;
        logic        prev_reg;
        prev_reg = 1'b0;

        row_known(REQ_TICK, PIN_UP,   32'd0, 3'b000, 3'b000, 3'b000, 32'd1);
        row_known(REQ_EDGE, PIN_NONE, 32'd5, 3'b111, 3'b000, 3'b000, 32'd1);
        row_reg(CFG_SIMPLE_ENABLE, 16'd7);
        row_reg(CFG_LONG_ENABLE, 16'd4);
        row_known(REQ_TICK, PIN_UP, 32'd100, 3'b011, 3'b011, 3'b000, 32'd0);
        row_item(REQ_TICK, PIN_UP, 32'd120,  3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd130,  3'b001);
        row_item(REQ_TICK, PIN_UP, 32'd200,  3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd300,  3'b100);
        row_item(REQ_TICK, PIN_UP, 32'd1301, 3'b100);
        row_item(REQ_TICK, PIN_UP, 32'd1400, 3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd1800, 3'b100);
        row_item(REQ_TICK, PIN_UP, 32'd1900, 3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd2000, 3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd2100, 3'b100);
        row_item(REQ_TICK, PIN_UP, 32'd2200, 3'b000);
        row_item(REQ_TICK, PIN_UP, 32'd2300, 3'b000);
        row_reg(CFG_SLEEP_MODE, 16'd1);
        row_item(REQ_EDGE, PIN_UP, 32'd2400, 3'b001);
        row_reg(CFG_SLEEP_MODE, 16'd0);
        row_reg(CFG_SWAP_UP_DOWN, 16'd1);
        row_item(REQ_EDGE, PIN_UP,   32'd2500, 3'b001);
        row_item(REQ_EDGE, PIN_DOWN, 32'd2600, 3'b101);
        row_reg(CFG_FILTER_TIME, 16'd0);
        row_reg(CFG_LONG_TIME, 16'd0);
        row_item(REQ_TICK, PIN_UP, 32'hFFFF_FFF0, 3'b111);
        row_item(REQ_TICK, PIN_UP, 32'h0000_0010, 3'b111);
        row_reg(CFG_FILTER_TIME, 16'hFFFF);
        row_reg(CFG_LONG_TIME, 16'hFFFF);
        row_reg(CFG_SWAP_UP_DOWN, 16'd0);
        row_item(REQ_EDGE, PIN_SELECT, 32'hFFFF_FFFF, 3'b000);
        row_item(REQ_TICK, PIN_UP,     32'h0001_0000, 3'b010);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < script.size(); r++) begin
            row = script[r];
            if (row.is_reg) begin
                if (!prev_reg) wait_quiet();
                cfg_write(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.req, row.pin, row.stamp, row.raw, row.fixed, row.want);
            end
            prev_reg = row.is_reg;
        end
        wait_quiet();
        stamp_ms = 32'h0002_0000;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct <= 75;
                rx_idle_pct <= 19;
            end
            if (phase == 2) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
                hold_req    <= 1'b1;
            end
            for (int chunk = 0; chunk < 6; chunk++) begin
                configure_random();
                run_chunk($urandom_range(115, 90));
                wait_quiet();
            end
        end

        $display("Covered %0d ticks and %0d pin edges across %0d register writes,",
                 ticks_seen, edges_seen, reg_writes);
        $display("with %0d results checked: %0d with clicks, %0d with long presses.",
                 results_seen, click_results, long_results);
        if (mismatches == 0) begin
            $display("button_debounce_click_long_press test passed");
        end else begin
            $display("button_debounce_click_long_press test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("button_debounce_click_long_press test failed");
        $finish;
    end

endmodule
